// ----- sv/circle_masked_intensity_argmin_assert.svh -----
// Assertion macros used by the darkest-circle selection RTL.
`ifndef CIRCLE_MASKED_INTENSITY_ARGMIN_ASSERT_SVH
`define CIRCLE_MASKED_INTENSITY_ARGMIN_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CMIA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CMIA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cmia_pkg.sv -----
// Package with constants, field widths and state type of the darkest-circle selector.
package cmia_pkg;

    localparam int MAX_CIRCLES_DEF = 16;
    localparam int MAX_SIDE_DEF    = 1024;

    localparam int COORD_W  = 10;
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 11;
    localparam int SUM_W    = 28;
    localparam int OSUM_W   = 24;
    localparam int OIDX_W   = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(64);
    localparam logic [SUM_W-1:0] SUM_LIMIT   = SUM_W'(9999999);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    // Operation codes carried in tuser on the input side
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SQ_DX,
        S_SQ_DY,
        S_SQ_R,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MUL_DX,
        MUL_DY,
        MUL_R
    } t_mul_sel;

endpackage

// ----- sv/circle_masked_intensity_argmin.sv -----
// Darkest-circle selector: masked intensity sums per loaded circle, argmin on last pixel.
//
// Load up to MAX_CIRCLES candidate circles (tuser = 0), then stream the grey
// pixels of one image in raster order (tuser = 1, tlast on the final pixel).
// The block tracks column and row itself, wrapping the column at the
// configured image width (0 acts as 1, values above MAX_SIDE act as
// MAX_SIDE) and the row after MAX_SIDE rows. A pixel is added to the
// 28-bit saturating sum of every circle whose squared center distance is
// strictly below its squared radius. On the last pixel one result is sent:
// the circle with the smallest sum below 9999999, lower load index on ties,
// with found = 0 and all-zero fields when no circle qualifies; then the
// circle count and the pixel position are cleared (each circle's sum is
// zeroed when it is loaded). Loads beyond capacity are dropped. A pixel is
// accepted, then goes through one table read and three squarings (dx, dy,
// radius) per loaded circle in one shared squaring unit, then finish.
// The last pixel also waits in its finish state while an earlier
// result still sits unclaimed in the output register. The block accepts one
// item at a time; tready is low while a pixel is being worked on. Write the
// image width only while the block is idle.
`include "circle_masked_intensity_argmin_assert.svh"

module circle_masked_intensity_argmin
    import cmia_pkg::*;
#(
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
    parameter int MAX_SIDE    = MAX_SIDE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: image width
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata, low to high: circle_x[9:0], circle_y[19:10], circle_radius[29:20],
    //   pixel_value[37:30], zero fill[39:38]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: operation (0 load circle, 1 pixel)
    input  logic                 i_s_axis_tuser,
    // tlast: last_pixel
    input  logic                 i_s_axis_tlast,
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata, low to high: best_index[3:0], best_x[13:4], best_y[23:14],
    //   best_radius[33:24], best_sum[57:34], zero fill[63:58]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: found
    output logic                 o_m_axis_tuser
);

    localparam int IW  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int CNW = $clog2(MAX_CIRCLES + 1);
    localparam int CW  = $clog2(MAX_SIDE);
    localparam int WW  = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int DW  = (CW > COORD_W) ? CW : COORD_W;
    localparam int SQW = 2 * DW;
    localparam int AW  = SQW + 1;

    // ---- state and control registers ----
    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_width;
    logic [CNW-1:0]    r_count;
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_col;
    logic [CW-1:0]     r_row;
    logic              r_out_valid;
    logic              r_found;

    // ---- payload registers ----
    logic [PIX_W-1:0]   r_pix;
    logic               r_last;
    logic [AW-1:0]      r_acc;
    logic [SUM_W-1:0]   r_best_sum;
    logic [IW-1:0]      r_best_idx;
    logic [COORD_W-1:0] r_best_x, r_best_y, r_best_r;
    logic [M_TDATA_W-1:0] r_out_data;
    logic               r_out_found;

    // ---- circle tables and sums ----
    logic [COORD_W-1:0] mem_x [MAX_CIRCLES];
    logic [COORD_W-1:0] mem_y [MAX_CIRCLES];
    logic [COORD_W-1:0] mem_r [MAX_CIRCLES];
    logic [SUM_W-1:0]   mem_sum [MAX_CIRCLES];
    logic [COORD_W-1:0] r_rd_x, r_rd_y, r_rd_r;
    logic [SUM_W-1:0]   r_rd_sum;

    // ---- decoded controls ----
    logic     s_ready;
    logic     in_xfer;
    logic     is_load;
    logic     table_full;
    logic     load_we;
    logic     sum_we;
    logic     fin_go;
    logic     last_circle;
    t_mul_sel mul_sel;

    // ---- datapath nets ----
    logic [DW-1:0]    col_ext, row_ext, x_ext, y_ext;
    logic [DW-1:0]    mul_a;
    logic [SQW-1:0]   sq;
    logic             inside_hit;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_sat, new_sum;
    logic [WW-1:0]    width_eff, col_next;
    logic [CW:0]      row_next;
    logic [SUM_W-1:0] res_sum;

    assign in_xfer     = i_s_axis_tvalid & s_ready;
    assign is_load     = (i_s_axis_tuser == OP_LOAD);
    assign table_full  = (r_count == CNW'(MAX_CIRCLES));
    assign load_we     = in_xfer & is_load & ~table_full;
    assign last_circle = ((CNW'(r_idx) + CNW'(1)) == r_count);

    // ---- next-state logic ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && !is_load) begin
                    n_state = (r_count == '0) ? S_FINISH : S_READ;
                end
            end
            S_READ:  n_state = S_SQ_DX;
            S_SQ_DX: n_state = S_SQ_DY;
            S_SQ_DY: n_state = S_SQ_R;
            S_SQ_R:  n_state = last_circle ? S_FINISH : S_READ;
            S_FINISH: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- output decode of the sequencer ----
    always_comb begin
        s_ready = 1'b0;
        sum_we  = 1'b0;
        fin_go  = 1'b0;
        mul_sel = MUL_DX;
        unique case (r_state)
            S_IDLE:  s_ready = 1'b1;
            S_READ:  mul_sel = MUL_DX;
            S_SQ_DX: mul_sel = MUL_DX;
            S_SQ_DY: mul_sel = MUL_DY;
            S_SQ_R: begin
                mul_sel = MUL_R;
                sum_we  = 1'b1;
            end
            // hold the last pixel while the previous result is unclaimed
            S_FINISH: fin_go = ~(r_last & r_out_valid & ~i_m_axis_tready);
            default: ;
        endcase
    end

    // ---- shared squaring unit ----
    assign col_ext = DW'(r_col);
    assign row_ext = DW'(r_row);
    assign x_ext   = DW'(r_rd_x);
    assign y_ext   = DW'(r_rd_y);

    always_comb begin
        unique case (mul_sel)
            MUL_DX:  mul_a = (col_ext >= x_ext) ? (col_ext - x_ext) : (x_ext - col_ext);
            MUL_DY:  mul_a = (row_ext >= y_ext) ? (row_ext - y_ext) : (y_ext - row_ext);
            MUL_R:   mul_a = DW'(r_rd_r);
            default: mul_a = '0;
        endcase
    end

    assign sq = mul_a * mul_a;

    // strictly inside: dx^2 + dy^2 < r^2
    assign inside_hit = (r_acc < {1'b0, sq});
    assign sum_add    = {1'b0, r_rd_sum} + (SUM_W + 1)'(r_pix);
    assign sum_sat    = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign new_sum    = inside_hit ? sum_sat : r_rd_sum;

    // ---- pixel position ----
    always_comb begin
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_SIDE)) begin
            width_eff = WW'(MAX_SIDE);
        end else begin
            width_eff = WW'(r_width);
        end
    end

    assign col_next = WW'(r_col) + WW'(1);
    assign row_next = {1'b0, r_row} + (CW + 1)'(1);

    // ---- memories: one write port, registered read at the sequencer index ----
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_x[r_count[IW-1:0]] <= i_s_axis_tdata[COORD_W-1:0];
            mem_y[r_count[IW-1:0]] <= i_s_axis_tdata[2*COORD_W-1:COORD_W];
            mem_r[r_count[IW-1:0]] <= i_s_axis_tdata[3*COORD_W-1:2*COORD_W];
        end
        r_rd_x <= mem_x[r_idx];
        r_rd_y <= mem_y[r_idx];
        r_rd_r <= mem_r[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_sum[r_count[IW-1:0]] <= '0;
        end else if (sum_we) begin
            mem_sum[r_idx] <= new_sum;
        end
        r_rd_sum <= mem_sum[r_idx];
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= WIDTH_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            if (load_we) begin
                r_count <= r_count + CNW'(1);
            end
            if (in_xfer && !is_load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (sum_we) begin
                // advance to the next circle; the final increment is dropped
                if (!last_circle) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (r_last && new_sum < r_best_sum) begin
                    r_found <= 1'b1;
                end
            end
            if (fin_go) begin
                if (r_last) begin
                    r_count <= '0;
                    r_col   <= '0;
                    r_row   <= '0;
                end else if (col_next >= width_eff) begin
                    r_col <= '0;
                    r_row <= (row_next >= (CW + 1)'(MAX_SIDE)) ? '0 : row_next[CW-1:0];
                end else begin
                    r_col <= col_next[CW-1:0];
                end
            end
            if (fin_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    assign res_sum = r_found ? r_best_sum : '0;

    always_ff @(posedge i_clk) begin
        if (in_xfer && !is_load) begin
            r_pix      <= i_s_axis_tdata[3*COORD_W+PIX_W-1:3*COORD_W];
            r_last     <= i_s_axis_tlast;
            r_best_sum <= SUM_LIMIT;
        end
        unique case (mul_sel)
            MUL_DX:  r_acc <= AW'(sq);
            MUL_DY:  r_acc <= r_acc + AW'(sq);
            MUL_R:   r_acc <= r_acc;
            default: r_acc <= r_acc;
        endcase
        // keep the running minimum; strict compare lets the lower index win ties
        if (sum_we && r_last && new_sum < r_best_sum) begin
            r_best_sum <= new_sum;
            r_best_idx <= r_idx;
            r_best_x   <= r_rd_x;
            r_best_y   <= r_rd_y;
            r_best_r   <= r_rd_r;
        end
        if (fin_go && r_last) begin
            r_out_found <= r_found;
            if (r_found) begin
                r_out_data <= {{(M_TDATA_W - OSUM_W - 3*COORD_W - OIDX_W){1'b0}},
                               res_sum[OSUM_W-1:0], r_best_r, r_best_y, r_best_x,
                               OIDX_W'(r_best_idx)};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_found;

    // ---- assertions ----
    `CMIA_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1,
        r_count <= CNW'(MAX_CIRCLES), "circle count beyond table capacity")
    `CMIA_ASSERT_NOW(a_idx_below_count, i_clk, i_rst_n,
        r_state == S_READ || r_state == S_SQ_DX || r_state == S_SQ_DY || r_state == S_SQ_R,
        CNW'(r_idx) < r_count, "sequencer index past loaded circles")
    `CMIA_ASSERT_NOW(a_best_below_limit, i_clk, i_rst_n, r_found,
        r_best_sum < SUM_LIMIT, "found set with sum not below limit")
    `CMIA_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, fin_go && r_last,
        r_count == '0 && r_col == '0 && r_row == '0 && r_out_valid,
        "image state not cleared after last pixel")
    `CMIA_ASSERT_NOW(a_col_in_range, i_clk, i_rst_n, 1'b1,
        WW'(r_col) < width_eff || r_col == '0, "column counter beyond image width")

endmodule
